FILE: hdl/mlpc_pkg.sv
`default_nettype none
package mlpc_pkg;

    localparam int INPUT_SIZE  = 3840;
    localparam int HIDDEN_SIZE = 25;
    localparam int OUTPUT_SIZE = 2;
    localparam int SIG_DEPTH   = 1024;

    localparam int HW_COLS  = INPUT_SIZE + 1;
    localparam int OW_COLS  = HIDDEN_SIZE + 1;
    localparam int HW_DEPTH = HIDDEN_SIZE * HW_COLS;
    localparam int OW_DEPTH = OUTPUT_SIZE * OW_COLS;
    localparam int HW_AW    = $clog2(HW_DEPTH);
    localparam int OW_AW    = $clog2(OW_DEPTH);
    localparam int POS_W    = $clog2(INPUT_SIZE + 1);
    localparam int HID_AW   = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;
    localparam int CNT_W    = $clog2(HIDDEN_SIZE + 2);
    localparam int SIG_AW   = $clog2(SIG_DEPTH);
    localparam int SUM_W    = 40;
    localparam int HFRAC    = 27;   // hidden sums Q.27
    localparam int OFRAC    = 28;   // output sums Q.28
    localparam int HB_SH    = 15;   // hidden bias alignment
    localparam int OB_SH    = 16;   // output bias alignment

    localparam logic [1:0] MODE_HW  = 2'd0;
    localparam logic [1:0] MODE_OW  = 2'd1;
    localparam logic [1:0] MODE_PIX = 2'd2;

    localparam logic [1:0] V_FACE  = 2'd0;
    localparam logic [1:0] V_OTHER = 2'd1;
    localparam logic [1:0] V_TIE   = 2'd2;

    typedef logic [15:0]        sig_rom_t [SIG_DEPTH];
    typedef logic signed [15:0] pix_rom_t [256];

    // Shift-subtract quotient for the table builders.
    function automatic longint unsigned const_udiv(input longint unsigned a,
                                                   input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid at the center of bin k, Q0.16.
    function automatic logic [15:0] sig_entry(input int k);
        longint n;
        longint e;
        longint unsigned an;
        longint unsigned t;
        longint unsigned u;
        longint unsigned term;
        longint unsigned big;
        longint unsigned d;
        longint unsigned v;
        n = 32 * longint'(k) + 16 - 16 * longint'(SIG_DEPTH);
        an = (n < 0) ? longint'(-n) : longint'(n);
        t = const_udiv(an << 30, longint'(2 * SIG_DEPTH));
        u = t >> 4;
        term = 64'd1 << 30;
        e = longint'(64'd1 << 30);
        for (int i = 1; i <= 14; i++)
        begin
            term = const_udiv((term * u) >> 30, longint'(i));
            if (i[0])
                e = e - longint'(term);
            else
                e = e + longint'(term);
        end
        big = (e < 0) ? 64'd0 : longint'(e);
        for (int i = 0; i < 4; i++)
            big = (big * big) >> 30;
        d = (64'd1 << 30) + big;
        v = const_udiv((64'd1 << 46) + (d >> 1), d);
        if (n < 0)
            v = (v > 64'd65536) ? 64'd0 : 64'd65536 - v;
        if (v > 64'd65535)
            v = 64'd65535;
        return v[15:0];
    endfunction

    function automatic sig_rom_t sig_build();
        sig_rom_t r;
        for (int k = 0; k < SIG_DEPTH; k++)
            r[k] = sig_entry(k);
        return r;
    endfunction

    // Byte to Q1.15 in [-1,1], rounded half away from zero.
    function automatic pix_rom_t pix_build();
        pix_rom_t r;
        longint num;
        longint rnd;
        longint x;
        for (int p = 0; p < 256; p++)
        begin
            num = (2 * longint'(p) - 255) * 32768;
            rnd = num + ((num >= 0) ? 127 : -127);
            if (rnd < 0)
                x = -longint'(const_udiv(longint'(-rnd), 64'd255));
            else
                x = longint'(const_udiv(longint'(rnd), 64'd255));
            if (x > 32767)
                x = 32767;
            r[p] = 16'(x);
        end
        return r;
    endfunction

    // Table bin for a sum with frac fraction bits; clamps outside [-8,8).
    function automatic logic [SIG_AW-1:0] sig_bin(input logic signed [SUM_W-1:0] z,
                                                  input int frac);
        logic signed [SUM_W:0] t;
        logic [SUM_W:0] s;
        t = $signed({z[SUM_W-1], z}) + $signed((SUM_W+1)'(64'd1 << (frac + 3)));
        s = t >> (frac + 4 - SIG_AW);
        if (t < 0)
            return '0;
        else if (s > (SUM_W+1)'(SIG_DEPTH - 1))
            return SIG_AW'(SIG_DEPTH - 1);
        else
            return s[SIG_AW-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/mlpc_in_if.sv
`default_nettype none
interface mlpc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [4:0]         unit_index;
    logic [11:0]        weight_index;
    logic signed [15:0] weight_value;
    logic [7:0]         pixel;
    logic               last_pixel;

    modport source (output valid, mode, unit_index, weight_index, weight_value,
                    pixel, last_pixel, input ready);
    modport sink (input valid, mode, unit_index, weight_index, weight_value,
                  pixel, last_pixel, output ready);
endinterface
`default_nettype wire

FILE: hdl/mlpc_out_if.sv
`default_nettype none
interface mlpc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [15:0] face_score;
    logic [15:0] other_score;

    modport source (output valid, verdict, face_score, other_score, input ready);
    modport sink (input valid, verdict, face_score, other_score, output ready);
endinterface
`default_nettype wire

FILE: hdl/mlpc_sig_rom.sv
`default_nettype none
module mlpc_sig_rom (
    input  logic                       clk,
    input  logic [mlpc_pkg::SIG_AW-1:0] addr,
    output logic [15:0]                data
);
    import mlpc_pkg::*;

    localparam sig_rom_t ROM = sig_build();

    // registered read
    always_ff @(posedge clk)
    begin
        data <= ROM[addr];
    end
endmodule
`default_nettype wire

FILE: hdl/mlp_two_layer_classifier_unit.sv
`default_nettype none
// Channel  Dir  Interface    Carries
// req      in   mlpc_in_if   weight loads (hidden / output) and pixels
// rsp      out  mlpc_out_if  verdict with face and other scores, one per image
//
// A pixel makes one read of the hidden weight memory per hidden unit; the single
// port of that memory sets the pace. The first pixel of an image adds a bias
// pass. A last pixel adds a sigmoid pass, then the two output sums and scores.
// Reset is asynchronous and clears control only. A verdict waits in the output
// register; the next request is taken meanwhile, and only a following verdict
// stalls until the first one is taken.
module mlp_two_layer_classifier_unit (
    input logic         clk,
    input logic         rst_n,
    mlpc_in_if.sink     req,
    mlpc_out_if.source  rsp
);
    import mlpc_pkg::*;

    localparam pix_rom_t PIX_ROM = pix_build();

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEED   = 3'd1;   // hidden sums <= bias
    localparam logic [2:0] S_ACC    = 3'd2;   // hidden sums += x * w
    localparam logic [2:0] S_ACT    = 3'd3;   // hidden sums <= sigmoid
    localparam logic [2:0] S_OUT    = 3'd4;   // output sum of one class
    localparam logic [2:0] S_SCORE  = 3'd5;   // table lookup of output sum
    localparam logic [2:0] S_SCWAIT = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]              st_reg;
    logic [POS_W-1:0]        pos_reg;
    logic                    last_reg;
    logic                    cls_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [HW_AW-1:0]        hw_addr_reg;
    logic                    p1_vld_reg;
    logic [CNT_W-1:0]        p1_h_reg;
    logic                    p2_vld_reg;
    logic [CNT_W-1:0]        p2_h_reg;
    logic signed [15:0]      x_reg;
    logic signed [SUM_W-1:0] prod_reg;
    logic signed [SUM_W-1:0] hold_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic [15:0]             score0_reg;
    logic [15:0]             score1_reg;
    logic                    out_vld_reg;
    logic [1:0]              verdict_reg;
    logic [15:0]             face_reg;
    logic [15:0]             other_reg;

    // memories
    logic signed [15:0]      hw_mem [HW_DEPTH];
    logic signed [15:0]      ow_mem [OW_DEPTH];
    logic signed [SUM_W-1:0] hs_mem [HIDDEN_SIZE];
    logic signed [15:0]      hw_q;
    logic signed [15:0]      ow_q;
    logic signed [SUM_W-1:0] hs_q;

    logic                    acc_req;
    logic                    hw_we;
    logic                    ow_we;
    logic [HW_AW-1:0]        hw_a;
    logic [OW_AW-1:0]        ow_a;
    logic [HID_AW-1:0]       hs_ra;
    logic                    hs_we;
    logic [HID_AW-1:0]       hs_wa;
    logic signed [SUM_W-1:0] hs_wd;
    logic signed [SUM_W:0]   ssum;
    logic                    iss;
    logic                    drained;
    logic                    load_out;
    logic [SIG_AW-1:0]       rom_addr;
    logic [15:0]             rom_q;

    assign req.ready   = (st_reg == S_IDLE);
    assign acc_req     = req.valid && req.ready;
    assign rsp.valid   = out_vld_reg;
    assign rsp.verdict = verdict_reg;
    assign rsp.face_score  = face_reg;
    assign rsp.other_score = other_reg;

    assign hw_we = acc_req && (req.mode == MODE_HW) &&
                   (int'(req.unit_index) < HIDDEN_SIZE) && (int'(req.weight_index) < HW_COLS);
    assign ow_we = acc_req && (req.mode == MODE_OW) &&
                   (int'(req.unit_index) < OUTPUT_SIZE) && (int'(req.weight_index) < OW_COLS);

    always_comb
    begin
        if (hw_we)
            hw_a = HW_AW'(req.unit_index) * HW_AW'(HW_COLS) + HW_AW'(req.weight_index);
        else
            hw_a = hw_addr_reg;
        if (ow_we)
            ow_a = OW_AW'(req.unit_index) * OW_AW'(OW_COLS) + OW_AW'(req.weight_index);
        else
            ow_a = OW_AW'(cls_reg) * OW_AW'(OW_COLS) + OW_AW'(cnt_reg);
    end

    // output phase: index 0 is the bias, activation h sits at index h+1
    assign hs_ra = (st_reg == S_OUT) ? HID_AW'(cnt_reg - 1'b1) : HID_AW'(cnt_reg);

    always_comb
    begin
        if (st_reg == S_OUT)
            iss = (cnt_reg <= CNT_W'(HIDDEN_SIZE));
        else if (st_reg == S_SEED || st_reg == S_ACC || st_reg == S_ACT)
            iss = (cnt_reg < CNT_W'(HIDDEN_SIZE));
        else
            iss = 1'b0;
    end
    assign drained = !iss && !p1_vld_reg && !p2_vld_reg;

    // saturating hidden accumulate
    assign ssum = $signed({hold_reg[SUM_W-1], hold_reg}) + $signed({prod_reg[SUM_W-1], prod_reg});

    always_comb
    begin
        hs_we = 1'b0;
        hs_wa = HID_AW'(p2_h_reg);
        hs_wd = '0;
        if (st_reg == S_SEED && p1_vld_reg)
        begin
            hs_we = 1'b1;
            hs_wa = HID_AW'(p1_h_reg);
            hs_wd = SUM_W'(hw_q) <<< HB_SH;
        end
        else if (st_reg == S_ACC && p2_vld_reg)
        begin
            hs_we = 1'b1;
            if (ssum[SUM_W] != ssum[SUM_W-1])
                hs_wd = ssum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            else
                hs_wd = ssum[SUM_W-1:0];
        end
        else if (st_reg == S_ACT && p2_vld_reg)
        begin
            hs_we = 1'b1;
            hs_wd = $signed({{(SUM_W-16){1'b0}}, rom_q});
        end
    end

    always_ff @(posedge clk)
    begin
        if (hw_we)
            hw_mem[hw_a] <= req.weight_value;
        hw_q <= hw_mem[hw_a];
    end

    always_ff @(posedge clk)
    begin
        if (ow_we)
            ow_mem[ow_a] <= req.weight_value;
        ow_q <= ow_mem[ow_a];
    end

    always_ff @(posedge clk)
    begin
        if (hs_we)
            hs_mem[hs_wa] <= hs_wd;
        hs_q <= hs_mem[hs_ra];
    end

    assign rom_addr = (st_reg == S_SCORE) ? sig_bin(acc_reg, OFRAC) : sig_bin(hs_q, HFRAC);

    mlpc_sig_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_q)
    );

    assign load_out = (st_reg == S_DONE) && (!out_vld_reg || rsp.ready);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            pos_reg     <= '0;
            last_reg    <= 1'b0;
            cls_reg     <= 1'b0;
            cnt_reg     <= '0;
            hw_addr_reg <= '0;
            p1_vld_reg  <= 1'b0;
            p1_h_reg    <= '0;
            p2_vld_reg  <= 1'b0;
            p2_h_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= iss;
            p1_h_reg   <= cnt_reg;
            p2_vld_reg <= p1_vld_reg;
            p2_h_reg   <= p1_h_reg;
            if (iss)
            begin
                cnt_reg     <= cnt_reg + 1'b1;
                hw_addr_reg <= hw_addr_reg + HW_AW'(HW_COLS);
            end

            if (load_out)
                out_vld_reg <= 1'b1;
            else if (rsp.ready)
                out_vld_reg <= 1'b0;

            unique case (st_reg)
                S_IDLE:
                begin
                    if (acc_req && req.mode == MODE_PIX)
                    begin
                        last_reg <= req.last_pixel;
                        cnt_reg  <= '0;
                        if (pos_reg < POS_W'(INPUT_SIZE))
                            pos_reg <= pos_reg + 1'b1;
                        if (pos_reg == '0)
                        begin
                            st_reg      <= S_SEED;
                            hw_addr_reg <= '0;
                        end
                        else if (pos_reg < POS_W'(INPUT_SIZE))
                        begin
                            st_reg      <= S_ACC;
                            hw_addr_reg <= HW_AW'(pos_reg) + 1'b1;
                        end
                        else if (req.last_pixel)
                            st_reg <= S_ACT;
                    end
                end
                S_SEED:
                begin
                    if (drained)
                    begin
                        st_reg      <= S_ACC;
                        cnt_reg     <= '0;
                        hw_addr_reg <= HW_AW'(1);
                    end
                end
                S_ACC:
                begin
                    if (drained)
                    begin
                        st_reg  <= last_reg ? S_ACT : S_IDLE;
                        cnt_reg <= '0;
                    end
                end
                S_ACT:
                begin
                    if (drained)
                    begin
                        st_reg  <= S_OUT;
                        cnt_reg <= '0;
                        cls_reg <= 1'b0;
                    end
                end
                S_OUT:
                begin
                    if (drained)
                        st_reg <= S_SCORE;
                end
                S_SCORE:
                begin
                    st_reg <= S_SCWAIT;
                end
                S_SCWAIT:
                begin
                    if (!cls_reg)
                    begin
                        cls_reg <= 1'b1;
                        cnt_reg <= '0;
                        st_reg  <= S_OUT;
                    end
                    else
                        st_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        pos_reg <= '0;
                        st_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (acc_req && req.mode == MODE_PIX)
            x_reg <= PIX_ROM[req.pixel];
        if (st_reg == S_ACC && p1_vld_reg)
        begin
            prod_reg <= SUM_W'(x_reg * hw_q);
            hold_reg <= hs_q;
        end
        if (st_reg == S_OUT && p1_vld_reg)
        begin
            if (p1_h_reg == '0)
                prod_reg <= SUM_W'(ow_q) <<< OB_SH;
            else
                prod_reg <= SUM_W'($signed({1'b0, hs_q[15:0]}) * ow_q);
        end
        if (st_reg == S_ACT && drained)
            acc_reg <= '0;
        else if (st_reg == S_SCWAIT)
            acc_reg <= '0;
        else if (st_reg == S_OUT && p2_vld_reg)
            acc_reg <= acc_reg + prod_reg;
        if (st_reg == S_SCWAIT && !cls_reg)
            score0_reg <= rom_q;
        // second score is held apart so a waiting verdict keeps its fields
        if (st_reg == S_SCWAIT && cls_reg)
            score1_reg <= rom_q;
        if (load_out)
        begin
            face_reg  <= score0_reg;
            other_reg <= score1_reg;
            if (score0_reg > score1_reg)
                verdict_reg <= V_FACE;
            else if (score0_reg == score1_reg)
                verdict_reg <= V_TIE;
            else
                verdict_reg <= V_OTHER;
        end
    end

    // write-back of unit h-2 never lands on the entry read this cycle
    a_no_rmw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_ACC && iss && p2_vld_reg) |-> (p2_h_reg != cnt_reg))
        else $error("hidden sum read and write-back hit one entry");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(INPUT_SIZE))
        else $error("pixel position past image size");

    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_req && req.mode == MODE_PIX && req.last_pixel) |=> (st_reg != S_IDLE))
        else $error("last pixel did not start classification");

    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DONE) |-> (!p1_vld_reg && !p2_vld_reg))
        else $error("pipeline busy at verdict");
endmodule
`default_nettype wire

FILE: verif/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlpc_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;   // unused code, block ignores it
    localparam int HOLD_CYCLES = 800;         // long receiver hold-off
    localparam int DRAIN_CYCLES = 300;        // quiet time after last verdict
    localparam int MAX_LEN = 8;               // longest image; sets hidden columns loaded

    typedef struct packed {
        logic [1:0]         mode;
        logic [4:0]         unit_index;
        logic [11:0]        weight_index;
        logic signed [15:0] weight_value;
        logic [7:0]         pixel;
        logic               last_pixel;
    } request_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [15:0] face_score;
        logic [15:0] other_score;
    } verdict_t;

    logic clk;
    logic rst_n;

    mlpc_in_if  req_if ();
    mlpc_out_if rsp_if ();

    mlp_two_layer_classifier_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.source),
        .rsp   (rsp_if.sink)
    );

    // Stimulus list and verdicts still owed by the block.
    request_t pending_requests[$];
    verdict_t owed_verdicts[$];

    // Own copy of the classifier state.
    logic signed [15:0] hid_w [HW_DEPTH];
    logic signed [15:0] out_w [OW_DEPTH];
    longint             hid_sum [HIDDEN_SIZE];
    int                 pix_count;
    logic [15:0]        sig_lut [SIG_DEPTH];

    int  errors;
    int  verdicts_seen;
    int  cyc;
    int  hold_left;
    bit  hold_done;
    bit  took;
    bit  calm;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
        cyc <= cyc + 1;

    // Long windows with no random idling on either side.
    assign calm = (cyc % 20000) < 3000;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Sigmoid at the center of bin k, Q0.16.
    function automatic logic [15:0] sigmoid_bin_value(input int k);
        longint n;
        longint e;
        longint unsigned an;
        longint unsigned u;
        longint unsigned term;
        longint unsigned big;
        longint unsigned d;
        longint unsigned v;
        n = 32 * longint'(k) + 16 - 16 * longint'(SIG_DEPTH);
        an = (n < 0) ? -n : n;
        u = ((an << 30) / (2 * SIG_DEPTH)) >> 4;
        term = 64'd1 << 30;
        e = 64'sd1 <<< 30;
        for (int i = 1; i <= 14; i++)
        begin
            term = ((term * u) >> 30) / i;
            if (i % 2)
                e -= longint'(term);
            else
                e += longint'(term);
        end
        big = (e < 0) ? 0 : e;
        for (int i = 0; i < 4; i++)
            big = (big * big) >> 30;
        d = (64'd1 << 30) + big;
        v = ((64'd1 << 46) + d / 2) / d;
        if (n < 0)
            v = (v > 65536) ? 0 : 65536 - v;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    function automatic logic [15:0] sigmoid_of(input longint z, input int frac);
        longint lim;
        longint unsigned idx;
        lim = 64'sd8 <<< frac;
        if (z < -lim)
            idx = 0;
        else if (z >= lim)
            idx = SIG_DEPTH - 1;
        else
            idx = (longint'(z + lim) * SIG_DEPTH) >> (frac + 4);
        if (idx > SIG_DEPTH - 1)
            idx = SIG_DEPTH - 1;
        return sig_lut[idx];
    endfunction

    function automatic longint pixel_q15(input logic [7:0] p);
        longint num;
        longint x;
        num = (2 * longint'(p) - 255) * 32768;
        x = (num + ((num >= 0) ? 127 : -127)) / 255;
        return (x > 32767) ? 32767 : x;
    endfunction

    function automatic longint clip40(input longint v);
        if (v > 64'sd549755813887)
            return 64'sd549755813887;
        if (v < -64'sd549755813888)
            return -64'sd549755813888;
        return v;
    endfunction

    // Advances the classifier state by one accepted request; queues a verdict
    // when the request closes an image.
    task automatic classify_request(input request_t r);
        longint x;
        longint s;
        logic [15:0] act [HIDDEN_SIZE];
        logic [15:0] score [2];
        verdict_t v;
        case (r.mode)
            MODE_HW:
                if (r.unit_index < HIDDEN_SIZE && r.weight_index < HW_COLS)
                    hid_w[r.unit_index * HW_COLS + r.weight_index] = r.weight_value;
            MODE_OW:
                if (r.unit_index < OUTPUT_SIZE && r.weight_index < OW_COLS)
                    out_w[r.unit_index * OW_COLS + r.weight_index] = r.weight_value;
            MODE_PIX:
            begin
                x = pixel_q15(r.pixel);
                // image start: reseed from the bias column
                if (pix_count == 0)
                    for (int h = 0; h < HIDDEN_SIZE; h++)
                        hid_sum[h] = longint'(hid_w[h * HW_COLS]) * 32768;
                // pixels past the end of the image add nothing
                if (pix_count < INPUT_SIZE)
                begin
                    for (int h = 0; h < HIDDEN_SIZE; h++)
                        hid_sum[h] = clip40(hid_sum[h] +
                            x * longint'(hid_w[h * HW_COLS + pix_count + 1]));
                    pix_count++;
                end
                if (r.last_pixel)
                begin
                    for (int h = 0; h < HIDDEN_SIZE; h++)
                        act[h] = sigmoid_of(hid_sum[h], HFRAC);
                    for (int c = 0; c < 2; c++)
                    begin
                        s = longint'(out_w[c * OW_COLS]) * 65536;
                        for (int h = 0; h < HIDDEN_SIZE; h++)
                            s += longint'(act[h]) * longint'(out_w[c * OW_COLS + h + 1]);
                        score[c] = sigmoid_of(s, OFRAC);
                    end
                    v.face_score = score[0];
                    v.other_score = score[1];
                    if (score[0] > score[1])
                        v.verdict = V_FACE;
                    else if (score[0] == score[1])
                        v.verdict = V_TIE;
                    else
                        v.verdict = V_OTHER;
                    owed_verdicts.push_back(v);
                    for (int h = 0; h < HIDDEN_SIZE; h++)
                        hid_sum[h] = 0;
                    pix_count = 0;
                end
            end
            default: ;
        endcase
    endtask

    // Driver: new request on the falling edge once the last one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!req_if.valid || took))
        begin
            if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 30))
            begin
                {req_if.mode, req_if.unit_index, req_if.weight_index, req_if.weight_value,
                 req_if.pixel, req_if.last_pixel} <= pending_requests.pop_front();
                req_if.valid <= 1'b1;
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // Accepted requests feed the predictor.
    always @(posedge clk)
    begin
        took <= req_if.valid && req_if.ready;
        if (rst_n && req_if.valid && req_if.ready)
            classify_request({req_if.mode, req_if.unit_index, req_if.weight_index,
                              req_if.weight_value, req_if.pixel, req_if.last_pixel});
    end

    // Hold-off counter: one long stretch once some verdicts have come back.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (!hold_done && verdicts_seen >= 12)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    // Receiver ready, forced low during the hold-off so the block backs up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
                rsp_if.ready <= 1'b0;
            else
                rsp_if.ready <= calm || ($urandom_range(99) >= 30);
        end
    end

    // Verdict checker.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            verdicts_seen <= verdicts_seen + 1;
            if (owed_verdicts.size() == 0)
                report_mismatch("unexpected verdict", rsp_if.verdict, -1);
            else
            begin
                want = owed_verdicts.pop_front();
                if (rsp_if.verdict !== want.verdict)
                    report_mismatch("verdict", rsp_if.verdict, want.verdict);
                if (rsp_if.face_score !== want.face_score)
                    report_mismatch("face_score", rsp_if.face_score, want.face_score);
                if (rsp_if.other_score !== want.other_score)
                    report_mismatch("other_score", rsp_if.other_score, want.other_score);
            end
        end
    end

    task automatic push_req(input logic [1:0] mode, input int unit, input int col,
                            input int w, input int p, input bit last);
        request_t r;
        r.mode = mode;
        r.unit_index = unit[4:0];
        r.weight_index = col[11:0];
        r.weight_value = w[15:0];
        r.pixel = p[7:0];
        r.last_pixel = last;
        pending_requests.push_back(r);
    endtask

    // Mostly moderate weights so sums land inside the sigmoid range.
    function automatic int rand_weight();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return $signed($urandom_range(1023)) - 512;
        else if (sel < 8)
            return $signed($urandom_range(8191)) - 4096;
        else
            return $signed($urandom_range(65535)) - 32768;
    endfunction

    function automatic int rand_pixel();
        case ($urandom_range(5))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic push_image(input int len);
        for (int i = 0; i < len; i++)
            push_req(MODE_PIX, $urandom_range(31), $urandom_range(4095),
                     $urandom_range(65535), rand_pixel(), i == len - 1);
    endtask

    initial
    begin
        int counted;
        int images;
        int len;
        int sel;
        errors = 0;
        verdicts_seen = 0;
        cyc = 0;
        hold_left = 0;
        hold_done = 0;
        took = 0;
        pix_count = 0;
        for (int k = 0; k < SIG_DEPTH; k++)
            sig_lut[k] = sigmoid_bin_value(k);
        for (int h = 0; h < HIDDEN_SIZE; h++)
            hid_sum[h] = 0;
        for (int i = 0; i < HW_DEPTH; i++)
            hid_w[i] = '0;
        for (int i = 0; i < OW_DEPTH; i++)
            out_w[i] = '0;

        req_if.valid = 1'b0;
        req_if.mode = MODE_HW;
        req_if.unit_index = '0;
        req_if.weight_index = '0;
        req_if.weight_value = '0;
        req_if.pixel = '0;
        req_if.last_pixel = 1'b0;
        rsp_if.ready = 1'b0;
        rst_n = 1'b0;

        // Hidden columns the images reach: bias plus MAX_LEN pixels. Unit 0 at
        // the top weight and unit 1 at the bottom push their sums past the
        // table range.
        for (int h = 0; h < HIDDEN_SIZE; h++)
            for (int c = 0; c <= MAX_LEN; c++)
                push_req(MODE_HW, h, c,
                         (h == 0) ? 32767 : (h == 1) ? -32768 : rand_weight(), 0, 0);
        // Output store all zero: both scores match, tie verdict.
        for (int i = 0; i < OW_DEPTH; i++)
            push_req(MODE_OW, i / OW_COLS, i % OW_COLS, 0, 0, 0);

        // Directed corner cases.
        push_req(MODE_NONE, 3, 5, 1234, 77, 1);         // unused mode
        push_req(MODE_HW, 25, 100, 32767, 0, 0);        // row out of range
        push_req(MODE_HW, 31, 4095, -1, 0, 0);
        push_req(MODE_HW, 3, HW_COLS, -32768, 0, 0);    // column out of range
        push_req(MODE_OW, 2, 0, 32767, 0, 0);
        push_req(MODE_OW, 0, OW_COLS, -32768, 0, 1);    // last flag on a load
        push_req(MODE_PIX, 0, 0, 0, 0, 1);              // one-pixel image, tie
        push_req(MODE_PIX, 0, 0, 0, 255, 0);
        push_req(MODE_PIX, 0, 0, 0, 0, 0);
        push_req(MODE_PIX, 0, 0, 0, 128, 1);
        for (int i = 0; i < OW_DEPTH; i++)
            push_req(MODE_OW, i / OW_COLS, i % OW_COLS, rand_weight(), 0, 0);
        push_req(MODE_PIX, 0, 0, 0, 255, 1);
        push_req(MODE_PIX, 0, 0, 0, 127, 1);

        // Random traffic: short images, weight updates, some noise.
        counted = 0;
        images = 0;
        while (counted < 100 || images < 20)
        begin
            sel = $urandom_range(99);
            if (sel < 60)
            begin
                len = $urandom_range(1, MAX_LEN);
                push_image(len);
                counted += len;
                images++;
            end
            else if (sel < 78)
            begin
                push_req(MODE_HW, $urandom_range(HIDDEN_SIZE - 1), $urandom_range(MAX_LEN + 4),
                         rand_weight(), $urandom_range(255), 1'($urandom_range(1)));
                counted++;
            end
            else if (sel < 92)
            begin
                push_req(MODE_OW, $urandom_range(OUTPUT_SIZE - 1),
                         $urandom_range(OW_COLS - 1), rand_weight(),
                         $urandom_range(255), 1'($urandom_range(1)));
                counted++;
            end
            else if (sel < 96)
                push_req(2'($urandom_range(1)), $urandom_range(31), $urandom_range(4095),
                         $urandom_range(65535), $urandom_range(255), 1'($urandom_range(1)));
            else
                push_req(MODE_NONE, $urandom_range(31), $urandom_range(4095),
                         $urandom_range(65535), $urandom_range(255), 1'($urandom_range(1)));
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all requests taken, all verdicts back, then a quiet spell.
        while (pending_requests.size() > 0 || req_if.valid)
            @(posedge clk);
        while (owed_verdicts.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
